// ===== rtl/core/interpolation_search_first_match_defines.svh =====
// Assertion macros shared by the checker of the interpolation search block.
// Depends on nothing; the macros expect clk_i and rst_ni in the enclosing scope.
`ifndef INTERPOLATION_SEARCH_FIRST_MATCH_DEFINES_SVH
`define INTERPOLATION_SEARCH_FIRST_MATCH_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ISFM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ISFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/isfm_pkg.sv =====
// Shared types and constants of the interpolation search block.
// Depends on nothing; isfm_div, the top level and the checker import it.
package isfm_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned OP_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FOUND   = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] value;
  } isfm_in_t;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] index;
  } isfm_out_t;

endpackage

// ===== rtl/core/isfm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module isfm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/isfm_div.sv =====
// Iterative multiply-then-divide unit: quot = (width * diff) / span, one quotient
// bit per cycle. Depends on isfm_pkg. Requires diff <= span and span > 0.
module isfm_div
  import isfm_pkg::*;
#(
  parameter int unsigned AW = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [AW-1:0]     width_i,
  input  logic [DATA_W-1:0] diff_i,
  input  logic [DATA_W-1:0] span_i,
  output logic              done_o,
  output logic [AW-1:0]     quot_o
);

  localparam int unsigned CNT_W = $clog2(AW + 1);

  typedef enum logic [1:0] {
    D_IDLE,
    D_MUL,
    D_DIV
  } div_state_e;

  div_state_e          state_q, state_d;
  logic [AW-1:0]       width_q, width_d;
  logic [DATA_W-1:0]   diff_q, diff_d;
  logic [DATA_W-1:0]   span_q, span_d;
  logic [DATA_W-1:0]   rem_q, rem_d;
  logic [AW-1:0]       low_q, low_d;
  logic [AW-1:0]       quot_q, quot_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                done_q, done_d;
  logic [AW+DATA_W-1:0] prod;
  logic [DATA_W:0]     trial;
  logic                fits;

  assign prod  = (AW + DATA_W)'(width_q) * (AW + DATA_W)'(diff_q);
  assign trial = {rem_q, low_q[AW-1]};
  assign fits  = trial >= {1'b0, span_q};

  always_comb begin
    state_d = state_q;
    width_d = width_q;
    diff_d  = diff_q;
    span_d  = span_q;
    rem_d   = rem_q;
    low_d   = low_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    case (state_q)
      D_IDLE: begin
        if (start_i) begin
          width_d = width_i;
          diff_d  = diff_i;
          span_d  = span_i;
          state_d = D_MUL;
        end
      end
      D_MUL: begin
        // The high part of the product is already below span.
        rem_d   = prod[AW+DATA_W-1:AW];
        low_d   = prod[AW-1:0];
        quot_d  = '0;
        cnt_d   = CNT_W'(AW);
        state_d = D_DIV;
      end
      D_DIV: begin
        if (fits) begin
          rem_d = DATA_W'(trial - {1'b0, span_q});
        end else begin
          rem_d = trial[DATA_W-1:0];
        end
        low_d  = low_q << 1;
        quot_d = (quot_q << 1) | AW'(fits);
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          done_d  = 1'b1;
          state_d = D_IDLE;
        end
      end
      default: begin
        state_d = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    width_q <= width_d;
    diff_q  <= diff_d;
    span_q  <= span_d;
    rem_q   <= rem_d;
    low_q   <= low_d;
    quot_q  <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/core/interpolation_search_first_match.sv =====
// Top level of the interpolation search block: a sequencer around one element RAM
// and one iterative multiply-divide unit. Depends on isfm_pkg, isfm_ram, isfm_div.
//
// The block keeps a list of signed 32-bit words in a RAM of DEPTH entries; the user
// must append them in ascending order, which the block itself does not enforce. A
// beat is accepted when start is high and busy is low. A clear beat empties the list,
// an append beat adds its value at the end (or reports the list full and drops it),
// and a search beat looks for its value. Clear and append never raise busy, so such
// beats may follow back to back. A search of a nonempty list raises busy and runs a
// loop of interpolation probes: each round reads the two range ends from the RAM
// (states S_LO, S_HI, S_CMP), runs the probe division in the divider (skipped when
// the end values are equal), then reads the probe (S_PRB, S_PCMP). After the loop
// S_FLO, S_FLO2, S_FHI and S_FHI2 check the final range ends, S_WK and S_WK2 are
// spent per equal neighbor while walking back to the first match, and S_FIN confirms
// it. The single RAM read port and the bit-serial divider set the length of a search.
// Every beat yields exactly one result, shown on result_o for one cycle while strobe_o
// is high, in the cycle after the last step of its work. The receiver cannot stall, so
// it must take the result in that cycle. The returned index is the low six bits of the
// element position.
module interpolation_search_first_match
  import isfm_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  isfm_in_t  item_i,
  output logic      busy,
  output logic      strobe_o,
  output isfm_out_t result_o
);

  localparam int unsigned AW = $clog2(DEPTH);      // element address width
  localparam int unsigned CW = $clog2(DEPTH + 1);  // fill count width
  localparam int unsigned PW = AW + 2;             // signed range bound width

  typedef enum logic [3:0] {
    S_IDLE,
    S_LO,
    S_HI,
    S_CMP,
    S_DIV,
    S_PRB,
    S_PCMP,
    S_FLO,
    S_FLO2,
    S_FHI,
    S_FHI2,
    S_WK,
    S_WK2,
    S_FIN
  } state_e;

  state_e                   state_q, state_d;
  logic [CW-1:0]            count_q, count_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  logic signed [DATA_W-1:0] alo_q, alo_d;
  logic signed [PW-1:0]     lo_q, lo_d;
  logic signed [PW-1:0]     hi_q, hi_d;
  logic [AW-1:0]            p_q, p_d;
  logic [AW-1:0]            cand_q, cand_d;
  logic                     strobe_q, strobe_d;
  isfm_out_t                res_q, res_d;

  logic                     accept;
  logic                     full;
  logic                     ram_we;
  logic [AW-1:0]            ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] rd_s;
  logic signed [PW-1:0]     n_s;
  logic signed [PW-1:0]     probe;
  logic signed [PW-1:0]     p_s;
  logic                     div_start;
  logic                     div_done;
  logic [AW-1:0]            div_quot;
  logic [AW-1:0]            div_width;
  logic [DATA_W-1:0]        div_diff;
  logic [DATA_W-1:0]        div_span;

  assign accept = start && (state_q == S_IDLE);
  assign full   = (count_q == CW'(DEPTH));
  assign ram_we = accept && (item_i.opcode == OP_APPEND) && !full;
  assign rd_s   = signed'(ram_rdata);
  assign n_s    = signed'(PW'(count_q));
  assign p_s    = signed'(PW'(p_q));

  // Operands of the probe division: (hi - lo) * (key - a[lo]) / (a[hi] - a[lo]).
  // Inside the loop a[lo] <= key <= a[hi], so both differences are nonnegative.
  assign div_width = AW'(hi_q - lo_q);
  assign div_diff  = DATA_W'(key_q - alo_q);
  assign div_span  = DATA_W'(rd_s - alo_q);

  // The probe already lies in [lo, hi]; the clamp keeps it there regardless.
  always_comb begin
    probe = lo_q + signed'(PW'(div_quot));
    if (probe > hi_q) begin
      probe = hi_q;
    end
    if (probe < lo_q) begin
      probe = lo_q;
    end
  end

  isfm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (item_i.value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  isfm_div #(
    .AW (AW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .width_i (div_width),
    .diff_i  (div_diff),
    .span_i  (div_span),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Sequencer. Every RAM read is issued in one state and its data used in the next.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    key_d     = key_q;
    alo_d     = alo_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    p_d       = p_q;
    cand_d    = cand_q;
    strobe_d  = 1'b0;
    res_d     = res_q;
    ram_raddr = lo_q[AW-1:0];
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          strobe_d     = 1'b1;
          res_d.status = ST_OK;
          res_d.index  = '0;
          if (item_i.opcode == OP_CLEAR) begin
            count_d = '0;
          end else if (item_i.opcode == OP_APPEND) begin
            if (full) begin
              res_d.status = ST_FULL;
            end else begin
              count_d = count_q + 1'b1;
            end
          end else if (item_i.opcode == OP_SEARCH) begin
            if (count_q == '0) begin
              res_d.status = ST_MISSING;
            end else begin
              // Search work begins; the result comes at the end.
              strobe_d = 1'b0;
              key_d    = item_i.value;
              lo_d     = '0;
              hi_d     = n_s - 1'b1;
              cand_d   = '0;
              state_d  = S_LO;
            end
          end
        end
      end
      S_LO: begin
        if (lo_q > hi_q) begin
          state_d = S_FLO;
        end else begin
          ram_raddr = lo_q[AW-1:0];
          state_d   = S_HI;
        end
      end
      S_HI: begin
        alo_d     = rd_s;
        ram_raddr = hi_q[AW-1:0];
        state_d   = S_CMP;
      end
      S_CMP: begin
        if ((alo_q <= key_q) && (key_q <= rd_s)) begin
          if (rd_s == alo_q) begin
            p_d     = lo_q[AW-1:0];
            state_d = S_PRB;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end else begin
          state_d = S_FLO;
        end
      end
      S_DIV: begin
        if (div_done) begin
          p_d     = probe[AW-1:0];
          state_d = S_PRB;
        end
      end
      S_PRB: begin
        ram_raddr = p_q;
        state_d   = S_PCMP;
      end
      S_PCMP: begin
        if (rd_s == key_q) begin
          cand_d  = p_q;
          state_d = S_FLO;
        end else if (rd_s > key_q) begin
          hi_d    = p_s - 1'b1;
          state_d = S_LO;
        end else begin
          lo_d    = p_s + 1'b1;
          state_d = S_LO;
        end
      end
      S_FLO: begin
        // After the loop the range ends themselves may hold the key.
        if (!lo_q[PW-1] && (lo_q < n_s)) begin
          ram_raddr = lo_q[AW-1:0];
          state_d   = S_FLO2;
        end else begin
          state_d = S_FHI;
        end
      end
      S_FLO2: begin
        if (rd_s == key_q) begin
          cand_d  = lo_q[AW-1:0];
          state_d = S_WK;
        end else begin
          state_d = S_FHI;
        end
      end
      S_FHI: begin
        if (!hi_q[PW-1] && (hi_q < n_s)) begin
          ram_raddr = hi_q[AW-1:0];
          state_d   = S_FHI2;
        end else begin
          state_d = S_WK;
        end
      end
      S_FHI2: begin
        if (rd_s == key_q) begin
          cand_d = hi_q[AW-1:0];
        end
        state_d = S_WK;
      end
      S_WK: begin
        // Walk back over equal neighbors toward the first match.
        if (cand_q != '0) begin
          ram_raddr = AW'(cand_q - 1'b1);
          state_d   = S_WK2;
        end else begin
          ram_raddr = cand_q;
          state_d   = S_FIN;
        end
      end
      S_WK2: begin
        if (rd_s == key_q) begin
          cand_d  = AW'(cand_q - 1'b1);
          state_d = S_WK;
        end else begin
          ram_raddr = cand_q;
          state_d   = S_FIN;
        end
      end
      S_FIN: begin
        strobe_d = 1'b1;
        if (rd_s == key_q) begin
          res_d.status = ST_FOUND;
          res_d.index  = IDX_W'(cand_q);
        end else begin
          res_d.status = ST_MISSING;
          res_d.index  = '0;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      strobe_q <= 1'b0;
      key_q    <= '0;
      alo_q    <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      p_q      <= '0;
      cand_q   <= '0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      strobe_q <= strobe_d;
      key_q    <= key_d;
      alo_q    <= alo_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      p_q      <= p_d;
      cand_q   <= cand_d;
      res_q    <= res_d;
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign strobe_o = strobe_q;
  assign result_o = res_q;

endmodule

// ===== rtl/core/isfm_checker.sv =====
// Port-level checker of the interpolation search block, bound to the top level.
// Depends on isfm_pkg and interpolation_search_first_match_defines.svh.
`include "interpolation_search_first_match_defines.svh"

module isfm_checker
  import isfm_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input isfm_in_t  item_i,
  input logic      busy,
  input logic      strobe_o,
  input isfm_out_t result_o
);

  // An accepted beat either answers at once or starts a search.
  `ISFM_ASSERT_NEXT(a_accept_answers, start && !busy, strobe_o || busy,
                    "accepted beat neither answered nor started a search")

  // A result only appears once the block is free again.
  `ISFM_ASSERT_NOW(a_strobe_idle, strobe_o, !busy, "result shown while busy")

  // A result always follows an accepted beat or running search work.
  `ISFM_ASSERT_NOW(a_strobe_cause, strobe_o, $past(busy || start),
                   "result without a preceding beat")

  // Only a search beat can make the block busy.
  `ISFM_ASSERT_NOW(a_busy_search, $rose(busy), $past(start && item_i.opcode == OP_SEARCH),
                   "busy raised without a search beat")

  // The index is zero for every result that is not a match.
  `ISFM_ASSERT_NOW(a_index_zero, strobe_o && result_o.status != ST_FOUND,
                   result_o.index == '0, "nonzero index without a match")

endmodule

bind interpolation_search_first_match isfm_checker u_isfm_checker (.*);
